// ===== design/pfcu_pkg.sv =====
// Package with the frame layout constants, status codes and result type of the pose frame checker.
package pfcu_pkg;

  localparam int unsigned FRAME_LEN = 24;
  localparam int unsigned POS_W = 5;
  localparam int unsigned SUM_W = 12;
  localparam int unsigned POSE_N = 7;
  localparam int unsigned STAT_N = 2;

  localparam logic [POS_W-1:0] POS_IDLE = POS_W'(FRAME_LEN);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] POS_HDR_END = 5'd3;
  localparam logic [POS_W-1:0] POS_POSE_END = 5'd17;
  localparam logic [POS_W-1:0] POS_STAT_END = 5'd19;
  localparam logic [POS_W-1:0] POS_CKS_HI = 5'd20;
  localparam logic [POS_W-1:0] POS_TRL_START = 5'd22;
  localparam logic [POS_W-1:0] POS_POSE_BASE = 5'd5;

  localparam logic [7:0] MARK_55 = 8'h55;
  localparam logic [7:0] MARK_AA = 8'hAA;
  localparam logic [7:0] MARK_BB = 8'hBB;

  localparam logic [1:0] STATUS_GOOD = 2'd0;
  localparam logic [1:0] STATUS_MARKER = 2'd1;
  localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

  typedef logic signed [15:0] pose_word_t;

  typedef struct packed {
    logic [1:0] frame_status;
    pose_word_t slam_x;
    pose_word_t slam_y;
    pose_word_t slam_z;
    pose_word_t slam_yaw;
    pose_word_t chassis_x;
    pose_word_t chassis_y;
    pose_word_t chassis_yaw;
    logic [7:0] slam_state_byte;
    logic [7:0] chassis_state_byte;
  } pfcu_result_t;

  function automatic logic [7:0] expected_marker(input logic [POS_W-1:0] pos);
    logic [7:0] m;
    m = MARK_BB;
    if (pos == 5'd0 || pos == 5'd1 || pos == POS_TRL_START) begin
      m = MARK_55;
    end else if (pos == 5'd2 || pos == POS_HDR_END) begin
      m = MARK_AA;
    end
    return m;
  endfunction

endpackage

// ===== design/pfcu_byte_if.sv =====
// Interface for the received byte channel.
interface pfcu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ===== design/pfcu_result_if.sv =====
// Interface for the frame result channel.
interface pfcu_result_if;
  import pfcu_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  pose_word_t slam_x;
  pose_word_t slam_y;
  pose_word_t slam_z;
  pose_word_t slam_yaw;
  pose_word_t chassis_x;
  pose_word_t chassis_y;
  pose_word_t chassis_yaw;
  logic [7:0] slam_state_byte;
  logic [7:0] chassis_state_byte;

  modport source (output valid, output frame_status, output slam_x, output slam_y,
                  output slam_z, output slam_yaw, output chassis_x, output chassis_y,
                  output chassis_yaw, output slam_state_byte, output chassis_state_byte,
                  input ready);
  modport sink (input valid, input frame_status, input slam_x, input slam_y,
                input slam_z, input slam_yaw, input chassis_x, input chassis_y,
                input chassis_yaw, input slam_state_byte, input chassis_state_byte,
                output ready);
endinterface

// ===== design/pfcu_frame_parser.sv =====
// Per-byte frame parser: position tracking, marker and checksum checks, field capture.
module pfcu_frame_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  frame_start_i,
  output logic                  res_valid_o,
  output pfcu_pkg::pfcu_result_t res_o
);
  import pfcu_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d, pos_eff;
  logic [SUM_W-1:0] sum_q, sum_d, sum_eff;
  logic             mbad_q, mbad_d, mbad_eff;
  logic             cbad_q, cbad_d, cbad_eff;
  logic [7:0]       hold_q, hold_d;
  pose_word_t       pose_stage_q [POSE_N];
  logic [7:0]       stat_stage_q [STAT_N];
  pose_word_t       good_pose_q [POSE_N];
  pose_word_t       good_pose_d [POSE_N];
  logic [7:0]       good_stat_q [STAT_N];
  logic [7:0]       good_stat_d [STAT_N];
  logic             active, is_marker, is_data, is_pose, is_last;
  logic [POS_W-1:0] pose_off;
  logic [2:0]       pose_idx;
  logic [15:0]      rx_sum;
  logic [1:0]       status;

  assign pos_eff  = frame_start_i ? '0 : pos_q;
  assign sum_eff  = frame_start_i ? '0 : sum_q;
  assign mbad_eff = frame_start_i ? 1'b0 : mbad_q;
  assign cbad_eff = frame_start_i ? 1'b0 : cbad_q;

  assign active    = accept_i && (pos_eff != POS_IDLE);
  assign is_marker = (pos_eff <= POS_HDR_END) || (pos_eff >= POS_TRL_START);
  assign is_data   = !is_marker && (pos_eff <= POS_STAT_END);
  assign is_pose   = is_data && (pos_eff <= POS_POSE_END);
  assign is_last   = pos_eff == POS_LAST;
  assign pose_off  = pos_eff - POS_POSE_BASE;
  assign pose_idx  = pose_off[3:1];
  assign rx_sum    = {hold_q, rx_byte_i};

  always_comb begin
    pos_d  = pos_q;
    sum_d  = sum_q;
    mbad_d = mbad_q;
    cbad_d = cbad_q;
    hold_d = hold_q;
    if (accept_i) begin
      pos_d  = pos_eff;
      sum_d  = sum_eff;
      mbad_d = mbad_eff;
      cbad_d = cbad_eff;
    end
    if (active) begin
      pos_d = pos_eff + 5'd1;
      if (is_marker) begin
        if (rx_byte_i != expected_marker(pos_eff)) begin
          mbad_d = 1'b1;
        end
      end else if (is_data) begin
        sum_d = sum_eff + {{(SUM_W-8){1'b0}}, rx_byte_i};
        if (is_pose && !pos_eff[0]) begin
          hold_d = rx_byte_i;
        end
      end else if (pos_eff == POS_CKS_HI) begin
        hold_d = rx_byte_i;
      end else if (rx_sum != {{(16-SUM_W){1'b0}}, sum_eff}) begin
        cbad_d = 1'b1;
      end
    end
  end

  always_comb begin
    priority if (mbad_d) begin
      status = STATUS_MARKER;
    end else if (cbad_d) begin
      status = STATUS_CHECKSUM;
    end else begin
      status = STATUS_GOOD;
    end
  end

  always_comb begin
    for (int i = 0; i < POSE_N; i++) begin
      good_pose_d[i] = good_pose_q[i];
    end
    for (int i = 0; i < STAT_N; i++) begin
      good_stat_d[i] = good_stat_q[i];
    end
    if (active && is_last && status == STATUS_GOOD) begin
      for (int i = 0; i < POSE_N; i++) begin
        good_pose_d[i] = pose_stage_q[i];
      end
      for (int i = 0; i < STAT_N; i++) begin
        good_stat_d[i] = stat_stage_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_IDLE;
      sum_q  <= '0;
      mbad_q <= 1'b0;
      cbad_q <= 1'b0;
      hold_q <= '0;
      for (int i = 0; i < POSE_N; i++) begin
        good_pose_q[i] <= '0;
      end
      for (int i = 0; i < STAT_N; i++) begin
        good_stat_q[i] <= '0;
      end
    end else begin
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      mbad_q <= mbad_d;
      cbad_q <= cbad_d;
      hold_q <= hold_d;
      good_pose_q <= good_pose_d;
      good_stat_q <= good_stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (active && is_pose && pos_eff[0]) begin
      pose_stage_q[pose_idx] <= {hold_q, rx_byte_i};
    end
    if (active && is_data && !is_pose) begin
      stat_stage_q[pos_eff[0]] <= rx_byte_i;
    end
  end

  assign res_valid_o = active && is_last;

  always_comb begin
    res_o.frame_status       = status;
    res_o.slam_x             = good_pose_d[0];
    res_o.slam_y             = good_pose_d[1];
    res_o.slam_z             = good_pose_d[2];
    res_o.slam_yaw           = good_pose_d[3];
    res_o.chassis_x          = good_pose_d[4];
    res_o.chassis_y          = good_pose_d[5];
    res_o.chassis_yaw        = good_pose_d[6];
    res_o.slam_state_byte    = good_stat_d[0];
    res_o.chassis_state_byte = good_stat_d[1];
  end

endmodule

// ===== design/pfcu_out_stage.sv =====
// Result register with a skid entry so a stalled receiver does not block the byte input until both entries are full.
module pfcu_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  pfcu_pkg::pfcu_result_t push_data_i,
  output logic                   push_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output pfcu_pkg::pfcu_result_t out_data_o
);
  import pfcu_pkg::*;

  logic         main_valid_q, main_valid_d;
  logic         skid_valid_q, skid_valid_d;
  pfcu_result_t main_q, main_d;
  pfcu_result_t skid_q, skid_d;
  logic         pop;

  assign pop = main_valid_q && out_ready_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = push_i;
        main_d       = push_data_i;
      end
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_valid_d = 1'b1;
        skid_d       = push_data_i;
      end else begin
        main_valid_d = 1'b1;
        main_d       = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign push_ready_o = !skid_valid_q;
  assign out_valid_o  = main_valid_q;
  assign out_data_o   = main_q;

endmodule

// ===== design/pose_frame_checker_unpacker_unit.sv =====
// Top level of the pose frame checker and unpacker.
//
// The in_i channel carries one received byte per request, with frame_start marking
// byte 0 of a frame. Bytes seen while no frame is open are dropped without a result.
// A frame is 24 bytes: header 55 55 AA AA, seven big-endian pose words, two status
// bytes, a 16-bit sum of bytes 4 to 19 and the trailer 55 BB.
// After byte 23 the out_o channel presents one request with frame_status (good,
// marker error or checksum error, marker error winning) and the last good pose and
// status bytes, which are replaced only by a good frame.
// Throughput is one byte per cycle while in_i.ready is high. After byte 23 is accepted the
// result is registered in the result register, or in the skid entry while that register is held.
// When the receiver stalls, one further result is held in a skid entry; only with
// both entries full does in_i.ready drop.
// Reset puts the parser in the idle state waiting for a frame start, clears the held
// pose and status values to zero and empties the result register.
module pose_frame_checker_unpacker_unit (
  input  logic  clk_i,
  input  logic  rst_ni,
  pfcu_byte_if.sink     in_i,
  pfcu_result_if.source out_o
);
  import pfcu_pkg::*;

  logic         accept;
  logic         res_valid;
  pfcu_result_t res;
  pfcu_result_t out_data;

  assign accept = in_i.valid && in_i.ready;

  pfcu_frame_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (in_i.rx_byte),
    .frame_start_i (in_i.frame_start),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  pfcu_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (res_valid),
    .push_data_i  (res),
    .push_ready_o (in_i.ready),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_data_o   (out_data)
  );

  assign out_o.frame_status       = out_data.frame_status;
  assign out_o.slam_x             = out_data.slam_x;
  assign out_o.slam_y             = out_data.slam_y;
  assign out_o.slam_z             = out_data.slam_z;
  assign out_o.slam_yaw           = out_data.slam_yaw;
  assign out_o.chassis_x          = out_data.chassis_x;
  assign out_o.chassis_y          = out_data.chassis_y;
  assign out_o.chassis_yaw        = out_data.chassis_yaw;
  assign out_o.slam_state_byte    = out_data.slam_state_byte;
  assign out_o.chassis_state_byte = out_data.chassis_state_byte;

endmodule

// ===== design/pfcu_checker.sv =====
// Port-level checker for the pose frame checker and its bind to the top level.
module pfcu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  frame_status_i,
  input logic [15:0] slam_x_i,
  input logic [7:0]  chassis_state_byte_i
);
  import pfcu_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (frame_status_i == STATUS_GOOD || frame_status_i == STATUS_MARKER
                     || frame_status_i == STATUS_CHECKSUM))
    else $error("Result carries an undefined frame status.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("Byte input stalled while no result is pending.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("Result appeared without a byte request in the previous cycle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(frame_status_i)
      && $stable(slam_x_i) && $stable(chassis_state_byte_i))
    else $error("Stalled result request changed or was dropped.");

endmodule

bind pose_frame_checker_unpacker_unit pfcu_checker u_pfcu_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_i.valid),
  .in_ready_i           (in_i.ready),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .frame_status_i       (out_o.frame_status),
  .slam_x_i             (out_o.slam_x),
  .chassis_state_byte_i (out_o.chassis_state_byte)
);
